// ----- design/itb_pkg.sv -----
// ----------------------------------------------------------------------------
// itb_pkg
// Command codes, field widths and controller/datapath handshake structs
// for the interval timer bank.
// ----------------------------------------------------------------------------
package itb_pkg;

  localparam int CMD_W   = 3;
  localparam int INDEX_W = 3;
  localparam int VALUE_W = 16;

  localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP    = 3'd4;

  typedef struct packed {
    logic latch;
    logic sweep_rd;
    logic idx_rd;
    logic exec;
  } itb_ctrl_t;

  typedef struct packed {
    logic in_update;
    logic sweep_last;
    logic out_busy;
  } itb_stat_t;

endpackage

// ----- design/itb_req_if.sv -----
// ----------------------------------------------------------------------------
// itb_req_if
// Command channel: one item carries a command, a timer index and a value.
// ----------------------------------------------------------------------------
interface itb_req_if;
  import itb_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [INDEX_W-1:0] timer_index;
  logic [VALUE_W-1:0] value;

  modport source (output valid, cmd, timer_index, value, input ready);
  modport sink   (input valid, cmd, timer_index, value, output ready);
endinterface

// ----- design/itb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// itb_rsp_if
// Result channel: reached flag, run flag and elapsed count of one timer.
// ----------------------------------------------------------------------------
interface itb_rsp_if #(
  parameter int COUNT_WIDTH = 15
);
  logic                   valid;
  logic                   ready;
  logic                   reached;
  logic                   running;
  logic [COUNT_WIDTH-1:0] count;

  modport source (output valid, reached, running, count, input ready);
  modport sink   (input valid, reached, running, count, output ready);
endinterface

// ----- design/itb_cfg_if.sv -----
// ----------------------------------------------------------------------------
// itb_cfg_if
// Configuration write channel for the maintain_period register.
// ----------------------------------------------------------------------------
interface itb_cfg_if;
  logic valid;
  logic ready;
  logic maintain_period;

  modport source (output valid, maintain_period, input ready);
  modport sink   (input valid, maintain_period, output ready);
endinterface

// ----- design/itb_ram.sv -----
// ----------------------------------------------------------------------------
// itb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itb_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/itb_ctrl.sv -----
// ----------------------------------------------------------------------------
// itb_ctrl
// Sequencer: accept an item, sweep the bank on update, read the addressed
// timer, then execute and load the result register.
// ----------------------------------------------------------------------------
module itb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  itb_pkg::itb_stat_t stat,
  output itb_pkg::itb_ctrl_t ctl
);
  import itb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = stat.in_update ? S_SWEEP : S_READ;
        end
      end
      S_SWEEP: begin
        ctl.sweep_rd = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_READ;
      end
      S_READ: begin
        ctl.idx_rd = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.out_busy) begin
          ctl.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/itb_dp.sv -----
// ----------------------------------------------------------------------------
// itb_dp
// Datapath: run flags, count RAM with written bits, saturating update,
// threshold check and the result register.
// ----------------------------------------------------------------------------
module itb_dp #(
  parameter int TIMERS      = 8,
  parameter int COUNT_WIDTH = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  itb_pkg::itb_ctrl_t           ctl,
  output itb_pkg::itb_stat_t           stat,
  input  logic [itb_pkg::CMD_W-1:0]    cmd,
  input  logic [itb_pkg::INDEX_W-1:0]  timer_index,
  input  logic [itb_pkg::VALUE_W-1:0]  value,
  input  logic                         cfg_we,
  input  logic                         cfg_data,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic                         rsp_reached,
  output logic                         rsp_running,
  output logic [COUNT_WIDTH-1:0]       rsp_count
);
  import itb_pkg::*;

  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int SUM_W = ((COUNT_WIDTH > VALUE_W) ? COUNT_WIDTH : VALUE_W) + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [CMD_W-1:0]       cmd_r;
  logic [INDEX_W-1:0]     idx_r;
  logic [VALUE_W-1:0]     val_r;
  logic                   maintain;
  logic [TIMERS-1:0]      run_flags;
  logic [TIMERS-1:0]      cnt_valid;
  logic [IDX_W-1:0]       ptr;
  logic [IDX_W-1:0]       wr_addr;
  logic                   wr_pend;

  logic [IDX_W-1:0]       addr;
  logic                   idx_ok;
  logic [COUNT_WIDTH-1:0] rd_data;

  logic [COUNT_WIDTH-1:0] sw_cnt;
  logic [SUM_W-1:0]       sw_sum;
  logic [COUNT_WIDTH-1:0] sw_sat;
  logic                   sw_we;

  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic                   cur_run;
  logic                   hit;
  logic [COUNT_WIDTH-1:0] new_cnt;
  logic                   new_run;
  logic                   new_reached;
  logic                   ex_we;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;

  assign addr   = IDX_W'(idx_r);
  assign idx_ok = 32'(idx_r) < TIMERS;

  assign stat.in_update  = (cmd == CMD_UPDATE);
  assign stat.sweep_last = (ptr == IDX_W'(TIMERS - 1));
  assign stat.out_busy   = rsp_valid && !rsp_ready;

  // saturating add on the entry read in the previous sweep cycle
  always_comb begin
    sw_cnt = cnt_valid[wr_addr] ? rd_data : '0;
    sw_sum = SUM_W'(sw_cnt) + SUM_W'(val_r);
    sw_sat = (sw_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : sw_sum[COUNT_WIDTH-1:0];
    sw_we  = wr_pend && run_flags[wr_addr];
  end

  always_comb begin
    cur_run     = idx_ok && run_flags[addr];
    cur_cnt     = (idx_ok && cnt_valid[addr]) ? rd_data : '0;
    hit         = cur_run && (SUM_W'(cur_cnt) >= SUM_W'(val_r));
    new_cnt     = cur_cnt;
    new_run     = cur_run;
    new_reached = 1'b0;
    ex_we       = 1'b0;
    if (idx_ok) begin
      case (cmd_r)
        CMD_CHECK: begin
          if (hit) begin
            new_reached = 1'b1;
            new_cnt     = maintain ? (cur_cnt - COUNT_WIDTH'(val_r)) : '0;
            ex_we       = 1'b1;
          end
        end
        CMD_RESTART: begin
          new_cnt = '0;
          new_run = 1'b1;
          ex_we   = 1'b1;
        end
        CMD_START: begin
          new_run = 1'b1;
        end
        CMD_STOP: begin
          new_run = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign ram_we    = sw_we || (ctl.exec && ex_we);
  assign ram_waddr = sw_we ? wr_addr : addr;
  assign ram_wdata = sw_we ? sw_sat : new_cnt;
  assign ram_re    = ctl.sweep_rd || ctl.idx_rd;
  assign ram_raddr = ctl.sweep_rd ? ptr : addr;

  itb_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (TIMERS),
    .AW    (IDX_W)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r <= cmd;
      idx_r <= timer_index;
      val_r <= value;
      ptr   <= '0;
    end else if (ctl.sweep_rd) begin
      ptr <= ptr + 1'b1;
    end
    wr_addr <= ptr;
    if (ctl.exec) begin
      rsp_reached <= idx_ok && new_reached;
      rsp_running <= idx_ok && new_run;
      rsp_count   <= idx_ok ? new_cnt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      maintain  <= 1'b0;
      run_flags <= '0;
      cnt_valid <= '0;
      wr_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        maintain <= cfg_data;
      end
      wr_pend <= ctl.sweep_rd;
      if (ctl.exec && idx_ok) begin
        run_flags[addr] <= new_run;
      end
      if (ram_we) begin
        cnt_valid[ram_waddr] <= 1'b1;
      end
      if (ctl.exec) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/interval_timer_bank.sv -----
// ----------------------------------------------------------------------------
// interval_timer_bank
// A bank of TIMERS interval timers, each with a run flag and a saturating
// COUNT_WIDTH-bit elapsed count, driven by update/check/restart/start/stop
// commands, one result item per command item.
// ----------------------------------------------------------------------------
// An update item passes through a sweep, a drain, a read and an execute
// state before the next acceptance: the counts sit in a single-port-read RAM,
// so the bank is swept one timer per cycle, followed by a drain state, one
// read of the addressed timer and the execute state. Every other command goes
// only through the read and execute states. A result waits in an output
// register, so the next item is accepted while it is held. The execute state
// stalls only while a previous result is still not taken. Counts come out of
// reset as zero through per-timer written bits; there is no clearing pass.
module interval_timer_bank #(
  parameter int TIMERS      = 8,
  parameter int COUNT_WIDTH = 15
) (
  input  logic             clk,
  input  logic             rst,
  itb_req_if.sink          req,
  itb_rsp_if.source        rsp,
  itb_cfg_if.sink          cfg
);
  import itb_pkg::*;

  itb_ctrl_t ctl;
  itb_stat_t stat;

  assign cfg.ready = 1'b1;

  itb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  itb_dp #(
    .TIMERS      (TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cmd         (req.cmd),
    .timer_index (req.timer_index),
    .value       (req.value),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.maintain_period),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_reached (rsp.reached),
    .rsp_running (rsp.running),
    .rsp_count   (rsp.count)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("item accepted while previous item still in work");

  a_ctl_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.latch, ctl.sweep_rd, ctl.idx_rd, ctl.exec}))
    else $error("controller issued overlapping commands");

  a_exec_loads_result: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |=> rsp.valid)
    else $error("execute did not present a result");

  a_no_exec_over_result: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !ctl.exec)
    else $error("result overwritten before taken");

endmodule
